// ===== rtl/wrv_pkg.sv =====
package wrv_pkg;

  localparam int unsigned MaxWindow = 256;
  localparam int unsigned WinW      = 9;
  localparam int unsigned PriceW    = 32;
  localparam int unsigned VolW      = 32;

  localparam logic [31:0] Lvl05 = 32'd32768;
  localparam logic [31:0] Lvl15 = 32'd98304;
  localparam logic [31:0] Lvl30 = 32'd196608;
  localparam logic [31:0] Lvl60 = 32'd393216;

  localparam logic [0:0] CfgShort = 1'b0;
  localparam logic [0:0] CfgLong  = 1'b1;

  localparam logic [1:0] TrendEqual   = 2'd0;
  localparam logic [1:0] TrendRising  = 2'd1;
  localparam logic [1:0] TrendFalling = 2'd2;

  typedef struct packed {
    logic [31:0] close_price;
    logic        restart;
  } in_t;

  typedef struct packed {
    logic [31:0] short_vol;
    logic [31:0] long_vol;
    logic [1:0]  trend;
    logic [2:0]  short_level;
    logic [2:0]  long_level;
    logic        enough_data;
  } out_t;

  // divider handshake between sequencer and shared divide unit
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  function automatic logic [2:0] vol_level(input logic [31:0] v);
    if (v < Lvl05) return 3'd0;
    if (v < Lvl15) return 3'd1;
    if (v < Lvl30) return 3'd2;
    if (v < Lvl60) return 3'd3;
    return 3'd4;
  endfunction

endpackage

// ===== rtl/wrv_ram.sv =====
module wrv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/wrv_div.sv =====
// Restoring 64/64 divider, one quotient bit per cycle.
module wrv_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wrv_pkg::div_req_t     req_i,
  output logic                  done_o,
  output logic [63:0]           quot_o
);
  logic [63:0] rem_q, rem_d, quot_q, quot_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[63]};
    done_o = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quot_d = req_i.num;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 64'(trial - {1'b0, den_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[63:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = quot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (req_i.start) den_q <= req_i.den;
  end
endmodule

// ===== rtl/windowed_return_volatility.sv =====
// One item at a time; in_ready_o returns the cycle after the result
//   beat is taken. Every return, the mean and the variance go through the shared
//   64-bit bit-serial divider, which sets the rate.
// Reset (rst_ni low, async): windows 20/100, history empty, no result pending.
module windowed_return_volatility (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  wrv_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output wrv_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [0:0]                cfg_index_i,
  input  logic [wrv_pkg::WinW-1:0]  cfg_data_i
);
  localparam int unsigned AW = $clog2(wrv_pkg::MaxWindow);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_RD0, S_RD1, S_RDW, S_RD2, S_DIVR, S_ACC, S_MEAN, S_DIVM,
    S_VAR, S_DIVV, S_SQRT, S_NEXT, S_OUT
  } state_e;

  state_e state_q;
  logic [wrv_pkg::WinW-1:0]   short_win_q, long_win_q;
  logic [CW-1:0]              count_q;
  logic [AW-1:0]              wslot_q;
  logic                       phase_q;   // 0 short, 1 long
  logic                       pass_q;    // 0 sum, 1 squared deviation
  logic [CW-1:0]              n_q, j_q;
  logic [wrv_pkg::PriceW-1:0] prev_q, cur_q;
  logic                       neg_q;
  logic signed [40:0]         sum_q;
  logic signed [31:0]         mean_q;
  logic [63:0]                acc_q, sq_rem_q, sq_res_q, sq_bit_q;
  logic [wrv_pkg::VolW-1:0]   sv_q;
  wrv_pkg::out_t              out_q;

  logic [AW-1:0]              raddr;
  logic [wrv_pkg::PriceW-1:0] rdata;
  logic                       div_done;
  logic [63:0]                div_quot;
  wrv_pkg::div_req_t          div_req;
  logic                       we;

  logic [wrv_pkg::WinW-1:0]   win;
  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              m;
  logic [63:0]                ret_mag_sat;
  logic signed [32:0]         ret;
  logic signed [33:0]         dev;
  logic [31:0]                adev;
  logic [63:0]                sqr;
  logic [63:0]                sq_trial;
  logic [wrv_pkg::VolW-1:0]   lv;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign we = in_valid_i && in_ready_o;

  // restart puts the new price in slot 0
  wrv_ram #(.Width(wrv_pkg::PriceW), .Depth(wrv_pkg::MaxWindow)) u_ring (
    .clk_i, .we_i(we),
    .waddr_i(in_data_i.restart ? AW'(0) : wslot_q),
    .wdata_i(in_data_i.close_price), .raddr_i(raddr), .rdata_o(rdata)
  );

  wrv_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(div_quot));

  // ring position of the j-th price of the newest n; ring depth is a power of two
  assign raddr = AW'(wslot_q - AW'(n_q) + AW'(j_q));

  always_comb begin
    win   = phase_q ? long_win_q : short_win_q;
    n_eff = (CW'(win) < count_q) ? CW'(win) : count_q;
    m     = n_q - CW'(1);
    // quotient holds after done, so the return is still there in S_ACC
    if (neg_q) ret_mag_sat = (div_quot > 64'h8000_0000) ? 64'h8000_0000 : div_quot;
    else       ret_mag_sat = (div_quot > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : div_quot;
    ret  = neg_q ? -$signed({1'b0, ret_mag_sat[31:0]}) : $signed({1'b0, ret_mag_sat[31:0]});
    if (prev_q == '0) ret = '0;
    // |ret - mean| < 2^32, so the square stays 32 x 32
    dev  = 34'(ret) - 34'(mean_q);
    adev = dev[33] ? 32'(-dev) : 32'(dev);
    sqr  = adev * adev;
    sq_trial = sq_res_q + sq_bit_q;
    lv = (sq_res_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq_res_q[31:0];
  end

  // divider is started for each return in both passes, once for the mean and once for the variance
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = 64'd1;
    unique case (state_q)
      S_RD2: begin
        div_req.start = 1'b1;
        div_req.num = (rdata >= prev_q) ? {2'b0, 32'(rdata - prev_q), 30'b0}
                                        : {2'b0, 32'(prev_q - rdata), 30'b0};
        div_req.den = (prev_q == '0) ? 64'd1 : {32'b0, prev_q};
      end
      S_MEAN: begin
        div_req.start = 1'b1;
        div_req.num = sum_q[40] ? 64'(-sum_q) : 64'(sum_q);
        div_req.den = 64'(m);
      end
      S_VAR: begin
        // acc * 10000 as shifts and adds
        div_req.start = 1'b1;
        div_req.num = (acc_q << 13) + (acc_q << 10) + (acc_q << 9) + (acc_q << 8)
                    + (acc_q << 4);
        div_req.den = 64'(m);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      short_win_q <= 9'd20;
      long_win_q  <= 9'd100;
      count_q     <= '0;
      wslot_q     <= '0;
      out_valid_o <= 1'b0;
      phase_q     <= 1'b0;
      pass_q      <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      neg_q       <= 1'b0;
      sum_q       <= '0;
      mean_q      <= '0;
      acc_q       <= '0;
      sq_rem_q    <= '0;
      sq_res_q    <= '0;
      sq_bit_q    <= '0;
      sv_q        <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          wrv_pkg::CfgShort: short_win_q <= cfg_data_i;
          wrv_pkg::CfgLong:  long_win_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (we) begin
          wslot_q <= in_data_i.restart ? AW'(1) : AW'(wslot_q + AW'(1));
          if (in_data_i.restart) count_q <= CW'(1);
          else if (count_q < CW'(wrv_pkg::MaxWindow)) count_q <= count_q + CW'(1);
          phase_q <= 1'b0;
          sv_q    <= '0;
          state_q <= S_WIN;
        end
        S_WIN: begin
          n_q    <= n_eff;
          j_q    <= '0;
          pass_q <= 1'b0;
          sum_q  <= '0;
          acc_q  <= '0;
          if (n_eff < CW'(2)) begin
            sq_res_q <= '0;
            state_q  <= S_NEXT;
          end else state_q <= S_RD0;
        end
        S_RD0: state_q <= S_RD1;          // oldest price address presented
        S_RD1: begin
          prev_q  <= rdata;
          j_q     <= j_q + CW'(1);
          state_q <= S_RDW;
        end
        S_RDW: state_q <= S_RD2;          // next price address presented
        S_RD2: begin
          cur_q   <= rdata;
          neg_q   <= rdata < prev_q;
          state_q <= S_DIVR;
        end
        S_DIVR: if (div_done) state_q <= S_ACC;
        S_ACC: begin
          if (!pass_q) sum_q <= sum_q + 41'(ret);
          else acc_q <= acc_q + (sqr >> 28);
          prev_q <= cur_q;
          if (j_q == m) begin
            state_q <= pass_q ? S_VAR : S_MEAN;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_RDW;
          end
        end
        S_MEAN: state_q <= S_DIVM;
        S_DIVM: if (div_done) begin
          // mean truncated toward zero
          mean_q  <= sum_q[40] ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
          pass_q  <= 1'b1;
          j_q     <= '0;
          state_q <= S_RD0;
        end
        S_VAR: state_q <= S_DIVV;
        S_DIVV: if (div_done) begin
          sq_rem_q <= div_quot;
          sq_res_q <= '0;
          sq_bit_q <= 64'h4000_0000_0000_0000;
          state_q  <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle, 32 steps
          if (sq_bit_q == '0) state_q <= S_NEXT;
          else begin
            if (sq_rem_q >= sq_trial) begin
              sq_rem_q <= sq_rem_q - sq_trial;
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else sq_res_q <= sq_res_q >> 1;
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        S_NEXT: begin
          if (!phase_q) begin
            sv_q    <= lv;
            phase_q <= 1'b1;
            state_q <= S_WIN;
          end else state_q <= S_OUT;
        end
        S_OUT: begin
          // with fewer than two prices both windows are zero already
          out_q.enough_data <= count_q >= CW'(2);
          out_q.short_vol   <= sv_q;
          out_q.long_vol    <= lv;
          out_q.short_level <= wrv_pkg::vol_level(sv_q);
          out_q.long_level  <= wrv_pkg::vol_level(lv);
          out_q.trend <= (sv_q > lv) ? wrv_pkg::TrendRising :
                         (sv_q < lv) ? wrv_pkg::TrendFalling : wrv_pkg::TrendEqual;
          out_valid_o <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_data_o = out_q;
endmodule

// ===== rtl/wrv_checker.sv =====
module wrv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input wrv_pkg::out_t out_data_o
);
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after input beat");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");
  a_trend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.short_vol > out_data_o.long_vol
    |-> out_data_o.trend == wrv_pkg::TrendRising) else $error("bad trend");
  a_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.enough_data |-> out_data_o.short_vol == 32'd0
    && out_data_o.long_vol == 32'd0) else $error("vol without data");
endmodule

bind windowed_return_volatility wrv_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== bench/vol_checker.sv =====
`timescale 1ns / 1ps

module vol_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  wrv_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  wrv_pkg::out_t out_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [8:0]    cfg_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            results_seen_o
);

  logic [31:0]   hist_ring [wrv_pkg::MaxWindow];
  int unsigned   hist_count;
  int unsigned   hist_slot;
  logic [8:0]    short_win;
  logic [8:0]    long_win;
  wrv_pkg::out_t expected_vols[$];

  function automatic longint calc_return(logic [31:0] prev, logic [31:0] cur);
    longint unsigned q;
    if (prev == 0) return 0;
    if (cur >= prev) begin
      q = ({32'd0, cur - prev} << 30) / {32'd0, prev};
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    end
    q = ({32'd0, prev - cur} << 30) / {32'd0, prev};
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return -longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] price_back(int unsigned n, int unsigned j);
    return hist_ring[(hist_slot + wrv_pkg::MaxWindow - n + j) % wrv_pkg::MaxWindow];
  endfunction

  function automatic logic [31:0] window_vol(logic [8:0] win);
    int unsigned n;
    int unsigned m;
    longint sum = 0;
    longint mean;
    longint d;
    longint unsigned ad;
    longint unsigned acc = 0;
    longint unsigned root;
    n = (win < hist_count) ? win : hist_count;
    if (n < 2) return 0;
    m = n - 1;
    for (int unsigned j = 1; j < n; j++)
      sum += calc_return(price_back(n, j - 1), price_back(n, j));
    mean = sum / longint'(m);
    for (int unsigned j = 1; j < n; j++) begin
      d = calc_return(price_back(n, j - 1), price_back(n, j)) - mean;
      ad = (d < 0) ? longint'(-d) : longint'(d);
      acc += (ad * ad) >> 28;
    end
    root = int_sqrt(acc * 10000 / m);
    if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
    return root[31:0];
  endfunction

  function automatic logic [2:0] vol_class(logic [31:0] v);
    if (v < wrv_pkg::Lvl05) return 3'd0;
    if (v < wrv_pkg::Lvl15) return 3'd1;
    if (v < wrv_pkg::Lvl30) return 3'd2;
    if (v < wrv_pkg::Lvl60) return 3'd3;
    return 3'd4;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wrv_pkg::out_t exp_r;
    if (!rst_ni) begin
      hist_count     = 0;
      hist_slot      = 0;
      short_win      = 9'd20;
      long_win       = 9'd100;
      fail_count_o   = 0;
      results_seen_o = 0;
      expected_vols.delete();
      pending_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == wrv_pkg::CfgShort) short_win = cfg_data_i;
        else long_win = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.restart) begin
          hist_count = 0;
          hist_slot  = 0;
        end
        hist_ring[hist_slot] = in_data_i.close_price;
        hist_slot = (hist_slot + 1) % wrv_pkg::MaxWindow;
        if (hist_count < wrv_pkg::MaxWindow) hist_count++;
        exp_r = '0;
        if (hist_count >= 2) begin
          exp_r.enough_data = 1'b1;
          exp_r.short_vol   = window_vol(short_win);
          exp_r.long_vol    = window_vol(long_win);
          exp_r.trend = (exp_r.short_vol > exp_r.long_vol) ? wrv_pkg::TrendRising :
                        (exp_r.short_vol < exp_r.long_vol) ? wrv_pkg::TrendFalling :
                        wrv_pkg::TrendEqual;
        end
        exp_r.short_level = vol_class(exp_r.short_vol);
        exp_r.long_level  = vol_class(exp_r.long_vol);
        expected_vols = {expected_vols, exp_r};
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (expected_vols.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result beat %p", $realtime, out_data_i);
        end else begin
          exp_r = expected_vols.pop_front();
          if (out_data_i !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p",
                       $realtime, exp_r, out_data_i);
          end
        end
      end
      pending_o = expected_vols.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  wrv_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  wrv_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [0:0]    cfg_index = wrv_pkg::CfgShort;
  logic [8:0]    cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit hold_done = 1'b0;
  logic [31:0] last_price = 32'h0001_0000;
  int items_sent = 0;
  int phases_run = 0;

  always #5 clk = ~clk;

  windowed_return_volatility u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  vol_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  // Receiver: bursts of ready, short stalls, an occasional long one,
  // plus one counted hold-off on request so the block backs up.
  initial begin
    int pick;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      out_ready <= (pick < 12);
      if (pick < 12) repeat ($urandom_range(1, 30)) @(posedge clk);
      else if (pick < 19) repeat ($urandom_range(1, 5)) @(posedge clk);
      else repeat ($urandom_range(50, 400)) @(posedge clk);
    end
  end

  // Register write, only while the block is idle.
  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then pause.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_windows(logic [8:0] sw, logic [8:0] lw);
    drain();
    write_reg(wrv_pkg::CfgShort, sw);
    write_reg(wrv_pkg::CfgLong, lw);
    phases_run++;
  endtask

  // One price beat; valid stays up across back-to-back beats.
  task automatic send_price(logic [31:0] price, bit restart);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{close_price: price, restart: restart};
    last_price = price;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly a random walk around the last price, sometimes any nonzero value.
  function automatic logic [31:0] next_price();
    logic [31:0] p;
    int step;
    if ($urandom_range(0, 7) == 0) begin
      p = $urandom();
    end else begin
      step = $urandom_range(0, 4000) - 2000;
      p = last_price + (last_price >> 12) * step / 100 + step;
    end
    return (p == 0) ? 32'd1 : p;
  endfunction

  task automatic random_items(int count, int restart_odds);
    for (int i = 0; i < count; i++)
      send_price(next_price(), restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset windows 20/100.
    send_price(32'h0001_0000, 1'b0);        // single price: not enough data
    send_price(32'h0001_0000, 1'b0);        // flat: zero vol, equal trend
    send_price(32'hFFFF_FFFF, 1'b0);        // huge up move: return saturates
    send_price(32'h0000_0001, 1'b0);        // crash to smallest price
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0001_0400, 1'b1);        // restart: history back to one price
    send_price(32'h0001_0000, 1'b0);
    drain();                                // sender waits for all results
    send_price(32'h0001_0200, 1'b0);
    send_price(32'h0000_FF00, 1'b0);

    set_windows(9'd0, 9'd1);                // degenerate windows
    send_price(32'h0002_0000, 1'b1);
    send_price(32'h0003_0000, 1'b0);
    send_price(32'h0001_0000, 1'b0);

    set_windows(9'd256, 9'd2);              // short beyond history, long minimal
    send_price(32'h0001_0000, 1'b1);
    for (int i = 0; i < 6; i++)
      send_price(32'h0001_0000 + ((i % 2) ? 32'h2000 : 32'h0), 1'b0);
    send_price(32'hAAAA_5555, 1'b0);
    send_price(32'h5555_AAAA, 1'b0);

    // Random phases with small windows; receiver hold-off during the first.
    for (int ph = 0; ph < 14; ph++) begin
      set_windows(9'($urandom_range(0, 7)), 9'($urandom_range(0, 9)));
      if (ph == 0) hold_req = 1'b1;
      random_items(45, 12);
    end

    // Long run without restart: ring wraps, stored count saturates.
    set_windows(9'd3, 9'd2);
    random_items(300, 0);
    // Full-depth windows over a full ring, only a few beats.
    set_windows(9'd256, 9'd255);
    random_items(3, 0);
    set_windows(9'd4, 9'd256);
    random_items(40, 0);
    random_items(15, 3);

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d price beats, %0d results, %0d window settings (0..256).",
             items_sent, results_seen, phases_run);
    $display("Restarts, flat and saturating returns, ring wrap and a long receiver stall.");
    if (fail_count == 0 && hold_done) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wrv_pkg.sv
rtl/wrv_ram.sv
rtl/wrv_div.sv
rtl/windowed_return_volatility.sv
rtl/wrv_checker.sv
bench/vol_checker.sv
bench/testbench.sv
